@@ design/strength_score_eviction_table_defines.svh @@
// Assertion helpers shared by the scoring table RTL.
// Both expect clk and rst_n in the scope of the caller.
`ifndef STRENGTH_SCORE_EVICTION_TABLE_DEFINES_SVH
`define STRENGTH_SCORE_EVICTION_TABLE_DEFINES_SVH

// Same-cycle implication.
`define SSET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sset_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sset_pkg;

  // action codes
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_RESCORE = 2'd1;
  localparam logic [1:0] ACT_VICTIM  = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_ENTRIES_IN_USE = 3'd0;
  localparam logic [2:0] CFG_W_IMPORTANCE   = 3'd1;
  localparam logic [2:0] CFG_W_RECENCY      = 3'd2;
  localparam logic [2:0] CFG_W_FREQUENCY    = 3'd3;
  localparam logic [2:0] CFG_W_DECAY        = 3'd4;
  localparam logic [2:0] CFG_PROTECT        = 3'd5;

  // register reset values
  localparam logic [6:0] RST_ENTRIES_IN_USE = 7'd0;
  localparam logic [7:0] RST_W_IMPORTANCE   = 8'd40;
  localparam logic [7:0] RST_W_RECENCY      = 8'd30;
  localparam logic [7:0] RST_W_FREQUENCY    = 8'd5;
  localparam logic [7:0] RST_W_DECAY        = 8'd1;
  localparam logic [6:0] RST_PROTECT        = 7'd90;

  // day arithmetic: 86400000 = 2^10 * 84375
  localparam int          TIME_W          = 48;
  localparam int          DAY_SHIFT       = 10;
  localparam int          XW              = TIME_W - DAY_SHIFT;
  localparam int          XSPLIT          = 19;
  localparam int          RECIP_W         = 22;
  localparam int          PPW             = XSPLIT + RECIP_W;
  localparam int          SUMW            = XW + RECIP_W;
  localparam int          DAY_RECIP_SHIFT = 38;
  localparam int          DAYS_W          = 22;
  localparam logic [16:0] DAY_ODD         = 17'd84375;
  localparam logic [21:0] DAY_RECIP       = 22'd3257812;

  // percent division by reciprocal, exact below 43690
  localparam logic [12:0] PCT_RECIP = 13'd5243;
  localparam int          PCT_SHIFT = 19;

  localparam logic [6:0] PERCENT      = 7'd100;
  localparam logic [6:0] SCORE_MAX    = 7'd100;
  localparam int         RECENCY_DAYS = 30;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [6:0]  importance;
    logic [47:0] touched_ms;
    logic [15:0] recall_cnt;
    logic [6:0]  initial_score;
    logic [47:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [6:0] changed_count;
    logic [5:0] victim_index;
    logic       victim_found;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  importance;
    logic [47:0] seen_ms;
    logic [15:0] recalls;
  } meta_t;

  typedef struct packed {
    logic [7:0] w_imp;
    logic [7:0] w_rec;
    logic [7:0] w_freq;
    logic [7:0] w_dec;
  } wgt_t;

  typedef struct packed {
    logic busy;
    logic wb_vld;
    logic changed;
  } pipe_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ design/sset_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sset_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire                  clk,
  input  wire                  meta_we,
  input  wire [AW-1:0]         meta_waddr,
  input  sset_pkg::meta_t      meta_wdata,
  input  wire                  score_we,
  input  wire [AW-1:0]         score_waddr,
  input  wire [6:0]            score_wdata,
  input  wire                  rd_en,
  input  wire [AW-1:0]         rd_addr,
  output sset_pkg::meta_t      rd_meta,
  output logic [6:0]           rd_score
);

  sset_pkg::meta_t meta_mem [DEPTH];
  logic [6:0]      score_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (rd_en) begin
      rd_meta <= meta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[score_waddr] <= score_wdata;
    end
    if (rd_en) begin
      rd_score <= score_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/sset_score.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sset_score #(
  parameter int AW = 6
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_vld,
  input  wire [AW-1:0]          in_addr,
  input  sset_pkg::meta_t       in_meta,
  input  wire [6:0]             in_score,
  input  wire [47:0]            now_ms,
  input  sset_pkg::wgt_t        wgt,
  output sset_pkg::pipe_stat_t  stat,
  output logic [AW-1:0]         wb_addr,
  output logic [6:0]            wb_score
);

  localparam int NS   = 9;
  localparam int NETW = 31;

  // floor(v / 100) for v below 43690
  function automatic logic [8:0] pct_div(input logic [14:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'(sset_pkg::PCT_RECIP);
    return p[27:sset_pkg::PCT_SHIFT];
  endfunction

  logic [NS-1:0]  vld_r;
  logic [AW-1:0]  addr_r [NS];
  logic [6:0]     old_r  [NS];
  logic [6:0]     imp_r  [5];
  logic [15:0]    rec_r  [5];

  logic [sset_pkg::XW-1:0]     x0_r, x1_r, x2_r, x3_r, prod_r;
  logic [sset_pkg::PPW-1:0]    pph_r, ppl_r;
  logic [sset_pkg::RECIP_W-1:0] qe_r, q3_r;
  logic [sset_pkg::DAYS_W-1:0] days_r;
  logic [14:0]                 pimp_r, prec_r;
  logic [23:0]                 pfreq_r, pfreq2_r;
  logic [29:0]                 pdec_r, pdec2_r, pdec3_r;
  logic [8:0]                  qimp_r, qrec_r;
  logic [24:0]                 pos_r;
  logic [NETW-1:0]             net_r;

  logic [47:0]                 diff;
  logic [sset_pkg::SUMW-1:0]   est;
  logic [sset_pkg::XW-1:0]     rem;
  logic [6:0]                  rec_base;
  logic [6:0]                  score;

  always_comb begin
    diff = now_ms - in_meta.seen_ms;
    est  = {pph_r, {sset_pkg::XSPLIT{1'b0}}} + sset_pkg::SUMW'(ppl_r);
    rem  = x3_r - prod_r;
    if (days_r < sset_pkg::DAYS_W'(sset_pkg::RECENCY_DAYS)) begin
      rec_base = sset_pkg::PERCENT - ({2'b00, days_r[4:0]} + {1'b0, days_r[4:0], 1'b0});
    end else begin
      rec_base = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    addr_r[0] <= in_addr;
    old_r[0]  <= in_score;
    imp_r[0]  <= in_meta.importance;
    rec_r[0]  <= in_meta.recalls;
    for (int k = 1; k < NS; k++) begin
      addr_r[k] <= addr_r[k-1];
      old_r[k]  <= old_r[k-1];
    end
    for (int k = 1; k < 5; k++) begin
      imp_r[k] <= imp_r[k-1];
      rec_r[k] <= rec_r[k-1];
    end

    // elapsed ms / 1024
    if (now_ms > in_meta.seen_ms) begin
      x0_r <= diff[47:sset_pkg::DAY_SHIFT];
    end else begin
      x0_r <= '0;
    end

    // reciprocal estimate, split in two partial products
    pph_r <= sset_pkg::PPW'(x0_r[sset_pkg::XW-1:sset_pkg::XSPLIT])
             * sset_pkg::PPW'(sset_pkg::DAY_RECIP);
    ppl_r <= sset_pkg::PPW'(x0_r[sset_pkg::XSPLIT-1:0])
             * sset_pkg::PPW'(sset_pkg::DAY_RECIP);
    x1_r  <= x0_r;

    qe_r <= est[sset_pkg::SUMW-1:sset_pkg::DAY_RECIP_SHIFT];
    x2_r <= x1_r;

    prod_r <= sset_pkg::XW'(qe_r) * sset_pkg::XW'(sset_pkg::DAY_ODD);
    q3_r   <= qe_r;
    x3_r   <= x2_r;

    // estimate is low by at most one
    if (rem >= sset_pkg::XW'(sset_pkg::DAY_ODD)) begin
      days_r <= q3_r + sset_pkg::DAYS_W'(1);
    end else begin
      days_r <= q3_r;
    end

    pimp_r  <= 15'(imp_r[4]) * 15'(wgt.w_imp);
    prec_r  <= 15'(rec_base) * 15'(wgt.w_rec);
    pfreq_r <= 24'(rec_r[4]) * 24'(wgt.w_freq);
    pdec_r  <= 30'(days_r) * 30'(wgt.w_dec);

    qimp_r   <= pct_div(pimp_r);
    qrec_r   <= pct_div(prec_r);
    pfreq2_r <= pfreq_r;
    pdec2_r  <= pdec_r;

    pos_r   <= 25'(qimp_r) + 25'(qrec_r) + 25'(pfreq2_r);
    pdec3_r <= pdec2_r;

    net_r <= NETW'(pos_r) - NETW'(pdec3_r);
  end

  // clamp to 0..100
  always_comb begin
    if (net_r[NETW-1]) begin
      score = '0;
    end else if (net_r > NETW'(sset_pkg::SCORE_MAX)) begin
      score = sset_pkg::SCORE_MAX;
    end else begin
      score = net_r[6:0];
    end
  end

  assign wb_addr      = addr_r[NS-1];
  assign wb_score     = score;
  assign stat.busy    = |vld_r;
  assign stat.wb_vld  = vld_r[NS-1];
  assign stat.changed = score != old_r[NS-1];

endmodule

`default_nettype wire

@@ design/sset_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "strength_score_eviction_table_defines.svh"

module sset_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  sset_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output sset_pkg::out_item_t   out_data,
  input  wire [6:0]             cfg_entries,
  input  wire [6:0]             cfg_protect,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  sset_pkg::meta_t       rd_meta,
  input  wire [6:0]             rd_score,
  output logic                  pipe_vld,
  output logic [AW-1:0]         pipe_addr,
  output logic [47:0]           now_ms,
  input  sset_pkg::pipe_stat_t  stat,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr
);

  localparam int CMPW = (CW > 7) ? CW : 7;

  sset_pkg::state_t    state_r, state_nxt;
  logic                accept, load_out, slot_ok, vic_hit;
  logic [CW-1:0]       n_nxt;
  logic                op_rescore_r, op_victim_r;
  logic [CW-1:0]       n_r, idx_r, chg_r;
  logic                rd_vld_r;
  logic [AW-1:0]       rd_addr_r;
  logic                found_r;
  logic [AW-1:0]       victim_r;
  logic [6:0]          best_r;
  logic [47:0]         now_r;
  logic                out_valid_r;
  sset_pkg::out_item_t out_data_r;

  // span, capped at the table depth
  always_comb begin
    if (CMPW'(cfg_entries) > CMPW'(DEPTH)) begin
      n_nxt = CW'(DEPTH);
    end else begin
      n_nxt = CW'(cfg_entries);
    end
    slot_ok = CMPW'(in_data.slot) < CMPW'(DEPTH);
    vic_hit = rd_vld_r && op_victim_r && (rd_meta.importance < cfg_protect)
              && (!found_r || (rd_score < best_r));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sset_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.action == sset_pkg::ACT_RESCORE ||
              in_data.action == sset_pkg::ACT_VICTIM) begin
            state_nxt = sset_pkg::ST_WALK;
          end else begin
            state_nxt = sset_pkg::ST_DONE;
          end
        end
      end
      sset_pkg::ST_WALK: begin
        if (idx_r >= n_r) begin
          state_nxt = sset_pkg::ST_DRAIN;
        end
      end
      sset_pkg::ST_DRAIN: begin
        if (!rd_vld_r && !stat.busy) begin
          state_nxt = sset_pkg::ST_DONE;
        end
      end
      sset_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = sset_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sset_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state_r != sset_pkg::ST_IDLE;
    accept   = in_valid && (state_r == sset_pkg::ST_IDLE);
    rd_en    = (state_r == sset_pkg::ST_WALK) && (idx_r < n_r);
    wr_en    = accept && (in_data.action == sset_pkg::ACT_WRITE) && slot_ok;
    load_out = (state_r == sset_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  end

  assign rd_addr   = idx_r[AW-1:0];
  assign wr_addr   = AW'(in_data.slot);
  assign pipe_vld  = rd_vld_r && op_rescore_r;
  assign pipe_addr = rd_addr_r;
  assign now_ms    = now_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sset_pkg::ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      chg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= load_out || (out_valid_r && out_stall);
      if (accept) begin
        found_r <= 1'b0;
        idx_r   <= '0;
        chg_r   <= '0;
      end else begin
        if (rd_en) begin
          idx_r <= idx_r + CW'(1);
        end
        if (stat.wb_vld && stat.changed) begin
          chg_r <= chg_r + CW'(1);
        end
        if (vic_hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
    if (accept) begin
      op_rescore_r <= in_data.action == sset_pkg::ACT_RESCORE;
      op_victim_r  <= in_data.action == sset_pkg::ACT_VICTIM;
      n_r          <= n_nxt;
      now_r        <= in_data.now_ms;
      victim_r     <= '0;
    end else if (vic_hit) begin
      victim_r <= rd_addr_r;
      best_r   <= rd_score;
    end
    if (load_out) begin
      out_data_r.changed_count <= 7'(chg_r);
      out_data_r.victim_index  <= 6'(victim_r);
      out_data_r.victim_found  <= found_r;
    end
  end

  `SSET_ASSERT_IMP(a_wb_in_rescore, stat.wb_vld, op_rescore_r && (state_r == sset_pkg::ST_WALK || state_r == sset_pkg::ST_DRAIN), "score write-back outside a rescore walk")
  `SSET_ASSERT_IMP(a_walk_bound, state_r == sset_pkg::ST_WALK, idx_r <= n_r, "walk index past span")
  `SSET_ASSERT_IMP(a_victim_in_span, found_r, CW'(victim_r) < n_r, "victim outside span")
  `SSET_ASSERT_NXT(a_out_from_done, !out_valid_r && state_r != sset_pkg::ST_DONE, !out_valid_r, "result beat raised outside done")

endmodule

`default_nettype wire

@@ design/strength_score_eviction_table.sv @@
// Scoring table of TABLE_DEPTH entries (importance, last access in ms, recall count, score)
// held in two single-port-read RAMs with registered read data. Each input beat carries one
// action and yields exactly one result beat. A write loads one slot (slots at or above the
// depth are dropped). A rescore walks the n = min(entries_in_use, depth) slots in use, one
// RAM read per cycle, through a 9-stage scoring pipeline (elapsed days by reciprocal
// multiply, weighted terms, clamp to 0..100) that writes each new score back, and reports
// how many scores changed. A victim search walks the same n slots and keeps the lowest
// score among entries below the protection threshold (lowest slot wins ties). The single
// RAM read port sets the walk to one entry per cycle. One action is worked at a time;
// in_stall is high while it runs, and the result sits in an output register until the
// sink takes it. Configuration is written through cfg_we/cfg_index/cfg_wdata and must
// only change while the block is idle. Slots read before they were ever written return
// unspecified contents.
`timescale 1ns / 1ps
`default_nettype none

module strength_score_eviction_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sset_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sset_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire [2:0]            cfg_index,
  input  wire [7:0]            cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // configuration registers
  logic [6:0]     entries_r;
  logic [6:0]     protect_r;
  sset_pkg::wgt_t wgt_r;

  // RAM ports
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  sset_pkg::meta_t      rd_meta;
  logic [6:0]           rd_score;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  sset_pkg::meta_t      meta_wdata;
  logic                 score_we;
  logic [AW-1:0]        score_waddr;
  logic [6:0]           score_wdata;

  // scoring pipeline
  logic                 pipe_vld;
  logic [AW-1:0]        pipe_addr;
  logic [47:0]          now_ms;
  sset_pkg::pipe_stat_t stat;
  logic [AW-1:0]        wb_addr;
  logic [6:0]           wb_score;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r    <= sset_pkg::RST_ENTRIES_IN_USE;
      wgt_r.w_imp  <= sset_pkg::RST_W_IMPORTANCE;
      wgt_r.w_rec  <= sset_pkg::RST_W_RECENCY;
      wgt_r.w_freq <= sset_pkg::RST_W_FREQUENCY;
      wgt_r.w_dec  <= sset_pkg::RST_W_DECAY;
      protect_r    <= sset_pkg::RST_PROTECT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sset_pkg::CFG_ENTRIES_IN_USE: entries_r    <= cfg_wdata[6:0];
        sset_pkg::CFG_W_IMPORTANCE:   wgt_r.w_imp  <= cfg_wdata;
        sset_pkg::CFG_W_RECENCY:      wgt_r.w_rec  <= cfg_wdata;
        sset_pkg::CFG_W_FREQUENCY:    wgt_r.w_freq <= cfg_wdata;
        sset_pkg::CFG_W_DECAY:        wgt_r.w_dec  <= cfg_wdata;
        sset_pkg::CFG_PROTECT:        protect_r    <= cfg_wdata[6:0];
        default: ; // unmapped index: dropped
      endcase
    end
  end

  // write beat loads the whole entry; rescore write-back only touches the score.
  // The two never coincide: beats are only taken with the pipeline empty.
  assign meta_wdata.importance = in_data.importance;
  assign meta_wdata.seen_ms    = in_data.touched_ms;
  assign meta_wdata.recalls    = in_data.recall_cnt;

  always_comb begin
    score_we = wr_en || stat.wb_vld;
    if (stat.wb_vld) begin
      score_waddr = wb_addr;
      score_wdata = wb_score;
    end else begin
      score_waddr = wr_addr;
      score_wdata = in_data.initial_score;
    end
  end

  sset_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_entries (entries_r),
    .cfg_protect (protect_r),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_meta     (rd_meta),
    .rd_score    (rd_score),
    .pipe_vld    (pipe_vld),
    .pipe_addr   (pipe_addr),
    .now_ms      (now_ms),
    .stat        (stat),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr)
  );

  sset_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk         (clk),
    .meta_we     (wr_en),
    .meta_waddr  (wr_addr),
    .meta_wdata  (meta_wdata),
    .score_we    (score_we),
    .score_waddr (score_waddr),
    .score_wdata (score_wdata),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_meta     (rd_meta),
    .rd_score    (rd_score)
  );

  sset_score #(
    .AW (AW)
  ) u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (pipe_vld),
    .in_addr  (pipe_addr),
    .in_meta  (rd_meta),
    .in_score (rd_score),
    .now_ms   (now_ms),
    .wgt      (wgt_r),
    .stat     (stat),
    .wb_addr  (wb_addr),
    .wb_score (wb_score)
  );

endmodule

`default_nettype wire

@@ tb/sv/sset_tb_pkg.sv @@
`timescale 1ns / 1ps

package sset_tb_pkg;
  import sset_pkg::*;

  localparam int        TABLE_SLOTS = 64;
  localparam logic [1:0] ACT_NONE   = 2'd3;   // unused action code, no effect
  localparam longint    MS_PER_DAY  = 86400000;
  localparam longint    FRESH_DAYS  = 30;
  localparam longint    FRESH_STEP  = 3;
  localparam longint    PCT         = 100;
  localparam longint    SCORE_CEIL  = 100;

  // Tracks the table contents and settings, and queues the expected result beats.
  class eviction_tracker;
    bit [6:0]  in_use;
    bit [7:0]  w_imp;
    bit [7:0]  w_rec;
    bit [7:0]  w_freq;
    bit [7:0]  w_dec;
    bit [6:0]  guard_level;
    bit [6:0]  imp_mem    [TABLE_SLOTS];
    bit [47:0] last_mem   [TABLE_SLOTS];
    bit [15:0] recall_mem [TABLE_SLOTS];
    bit [6:0]  score_mem  [TABLE_SLOTS];
    out_item_t expected_results[$];
    int unsigned result_count;
    int unsigned fault_count;
    int unsigned writes_seen;
    int unsigned rescores_seen;
    int unsigned changes_seen;
    int unsigned searches_seen;
    int unsigned victims_seen;
    int unsigned idle_seen;

    function new();
      in_use      = RST_ENTRIES_IN_USE;
      w_imp       = RST_W_IMPORTANCE;
      w_rec       = RST_W_RECENCY;
      w_freq      = RST_W_FREQUENCY;
      w_dec       = RST_W_DECAY;
      guard_level = RST_PROTECT;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        CFG_ENTRIES_IN_USE: in_use      = val[6:0];
        CFG_W_IMPORTANCE:   w_imp       = val;
        CFG_W_RECENCY:      w_rec       = val;
        CFG_W_FREQUENCY:    w_freq      = val;
        CFG_W_DECAY:        w_dec       = val;
        CFG_PROTECT:        guard_level = val[6:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // slots covered by a walk; anything above the depth is capped
    function int span();
      return (in_use > TABLE_SLOTS) ? TABLE_SLOTS : int'(in_use);
    endfunction

    function bit [6:0] fresh_score(int i, bit [47:0] at_ms);
      longint days;
      longint total;
      days = 0;
      if (at_ms > last_mem[i])
        days = longint'({16'd0, at_ms - last_mem[i]}) / MS_PER_DAY;
      total = longint'(imp_mem[i]) * longint'(w_imp) / PCT;
      if (days < FRESH_DAYS)
        total += (PCT - FRESH_STEP * days) * longint'(w_rec) / PCT;
      total += longint'(recall_mem[i]) * longint'(w_freq);
      total -= days * longint'(w_dec);
      if (total < 0)
        total = 0;
      else if (total > SCORE_CEIL)
        total = SCORE_CEIL;
      return 7'(total);
    endfunction

    function void note_fault(string what);
      fault_count++;
      if (fault_count <= 10)
        $display("[%0t] score table mismatch: %s", $time, what);
    endfunction

    // accepted input beat: update the table and queue its result
    function void note_action(in_item_t beat);
      out_item_t res;
      bit [6:0]  s;
      bit [6:0]  best;
      int        i;
      int        n;
      int        changed;
      res = '0;
      best = '0;
      changed = 0;
      n = span();
      case (beat.action)
        ACT_WRITE: begin
          imp_mem[beat.slot]    = beat.importance;
          last_mem[beat.slot]   = beat.touched_ms;
          recall_mem[beat.slot] = beat.recall_cnt;
          score_mem[beat.slot]  = beat.initial_score;
          writes_seen++;
        end
        ACT_RESCORE: begin
          for (i = 0; i < n; i++) begin
            s = fresh_score(i, beat.now_ms);
            if (s != score_mem[i])
              changed++;
            score_mem[i] = s;
          end
          res.changed_count = 7'(changed);
          rescores_seen++;
          changes_seen += changed;
        end
        ACT_VICTIM: begin
          for (i = 0; i < n; i++) begin
            if (imp_mem[i] < guard_level && (!res.victim_found || score_mem[i] < best)) begin
              best = score_mem[i];
              res.victim_index = 6'(i);
              res.victim_found = 1'b1;
            end
          end
          searches_seen++;
          if (res.victim_found)
            victims_seen++;
        end
        default: idle_seen++;
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      result_count++;
      if (expected_results.size() == 0) begin
        note_fault($sformatf("unexpected beat changed=%0d index=%0d found=%0d",
                             got.changed_count, got.victim_index, got.victim_found));
        return;
      end
      want = expected_results.pop_front();
      if (got.changed_count !== want.changed_count || got.victim_index !== want.victim_index ||
          got.victim_found !== want.victim_found)
        note_fault($sformatf("exp changed=%0d index=%0d found=%0d, got changed=%0d index=%0d found=%0d",
                             want.changed_count, want.victim_index, want.victim_found,
                             got.changed_count, got.victim_index, got.victim_found));
    endfunction
  endclass

endpackage

@@ tb/sv/tb_strength_score_eviction_table.sv @@
`timescale 1ns / 1ps

module tb_strength_score_eviction_table;
  import sset_pkg::*;
  import sset_tb_pkg::*;

  localparam int          PHASES        = 10;
  localparam int          BEATS_PER_PHASE = 55;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SINK_HOLD_CYCLES = 400;
  localparam int          SETTLE_CYCLES = 100;   // longer than a full 64-slot rescore
  localparam logic [47:0] DAY_MS        = 48'd86400000;
  localparam logic [47:0] DIRECTED_NOW  = 48'd1000 * DAY_MS + 48'd12345;
  localparam int unsigned LOOKBACK_MS   = 32'd3888000000;  // 45 days
  localparam int unsigned STEP_MS       = 32'd259200000;   // 3 days

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  eviction_tracker tracker;
  bit          slot_written [TABLE_SLOTS];
  logic [47:0] clock_ms;
  int          tx_gap_pct = 26;
  int          rx_stall_pct = 57;
  bit          sink_hold_pending = 1'b0;
  int unsigned beats_issued = 0;
  int unsigned cycle_count = 0;

  strength_score_eviction_table #(.TABLE_DEPTH(TABLE_SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Both handshakes are sampled at the edge, before any driver update lands.
  // Results are checked before the input is noted: a result can never belong
  // to a beat taken at the same edge, as the block registers its output.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_result(out_data);
      if (in_valid && !in_stall)
        tracker.note_action(in_data);
    end
  end

  // Sink side. Random stalls at the current rate; on request it holds off for
  // a long stretch so the result register fills and the block stalls its input.
  initial begin : sink_side
    forever begin
      @(posedge clk);
      if (sink_hold_pending) begin
        sink_hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (rx_stall_pct != 0) && ($urandom_range(99, 0) < rx_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("strength_score_eviction_table regression: fail");
    $finish;
  end

  // Length of the contiguous run of written slots from slot 0. Walks never go
  // past it, so no slot is ever read before it has been written.
  function automatic int written_prefix();
    int k;
    k = 0;
    while (k < TABLE_SLOTS && slot_written[k])
      k++;
    return k;
  endfunction

  function automatic in_item_t make_beat(logic [1:0] act, logic [5:0] slot, logic [6:0] imp,
                                         logic [47:0] last, logic [15:0] rec,
                                         logic [6:0] score, logic [47:0] at_ms);
    in_item_t beat;
    beat.action        = act;
    beat.slot          = slot;
    beat.importance    = imp;
    beat.touched_ms    = last;
    beat.recall_cnt    = rec;
    beat.initial_score = score;
    beat.now_ms        = at_ms;
    return beat;
  endfunction

  // Mostly plausible table traffic: accesses within the last 45 days of a
  // running clock, small recall counts, importance in range. The rest keeps the
  // raw random bits, so every field bit toggles and the clamps get exercised.
  function automatic in_item_t random_beat();
    in_item_t    beat;
    logic [159:0] noise;
    int unsigned roll;
    int          prefix;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    beat = noise[$bits(in_item_t)-1:0];
    prefix = written_prefix();
    roll = $urandom_range(99, 0);
    if (roll < 50) begin
      beat.action = ACT_WRITE;
      // fill the table from the bottom up so wider spans open up quickly
      if (prefix < TABLE_SLOTS && $urandom_range(9, 0) < 7)
        beat.slot = 6'(prefix);
      if ($urandom_range(9, 0) != 0)
        beat.importance = 7'($urandom_range(100, 0));
      else
        beat.importance = 7'($urandom_range(127, 101));
      roll = $urandom_range(99, 0);
      if (roll < 70)
        beat.touched_ms = clock_ms - 48'($urandom_range(LOOKBACK_MS, 0));
      else if (roll < 85)
        beat.touched_ms = clock_ms + 48'($urandom_range(10000, 0));
      roll = $urandom_range(99, 0);
      if (roll < 60)
        beat.recall_cnt = 16'($urandom_range(10, 0));
      else if (roll < 90)
        beat.recall_cnt = 16'($urandom_range(400, 0));
      if ($urandom_range(99, 0) < 85)
        beat.initial_score = 7'($urandom_range(100, 0));
    end else if (roll < 75) begin
      beat.action = ACT_RESCORE;
      if ($urandom_range(4, 0) != 0) begin
        clock_ms = clock_ms + 48'($urandom_range(STEP_MS, 0));
        beat.now_ms = clock_ms;
      end
    end else if (roll < 95) begin
      beat.action = ACT_VICTIM;
    end else begin
      beat.action = ACT_NONE;
    end
    return beat;
  endfunction

  // Present one beat, with random gaps ahead of it, and hold it until taken.
  task automatic offer(input in_item_t beat);
    while (tx_gap_pct != 0 && $urandom_range(99, 0) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    beats_issued++;
    if (beat.action == ACT_WRITE)
      slot_written[beat.slot] = 1'b1;
  endtask

  // Every beat yields exactly one result, so once all results are back the
  // block is idle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tracker.result_count < beats_issued)
      @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic load_settings(input logic [7:0] span_val, input logic [7:0] wi,
                               input logic [7:0] wr, input logic [7:0] wf,
                               input logic [7:0] wd, input logic [7:0] guard);
    wait_for_results();
    put_reg(CFG_ENTRIES_IN_USE, span_val);
    put_reg(CFG_W_IMPORTANCE, wi);
    put_reg(CFG_W_RECENCY, wr);
    put_reg(CFG_W_FREQUENCY, wf);
    put_reg(CFG_W_DECAY, wd);
    put_reg(CFG_PROTECT, guard);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int          p;
    int          k;
    int          prefix;
    logic [7:0]  span_val;
    logic [7:0]  wi;
    logic [7:0]  wr;
    logic [7:0]  wf;
    logic [7:0]  wd;
    logic [7:0]  guard;

    tracker = new();
    clock_ms = 48'h1000_0000_0000 | 48'($urandom());
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings cover no slots: walks find nothing.
    offer(make_beat(ACT_RESCORE, '0, '0, '0, '0, '0, DIRECTED_NOW));
    offer(make_beat(ACT_VICTIM, '0, '0, '0, '0, '0, '0));
    offer(make_beat(ACT_NONE, '1, '1, '1, '1, '1, '1));

    // Eight hand-built slots under the reset weights.
    load_settings(8'd8, RST_W_IMPORTANCE, RST_W_RECENCY, RST_W_FREQUENCY,
                  RST_W_DECAY, {1'b0, RST_PROTECT});
    // importance at the top, protected
    offer(make_beat(ACT_WRITE, 6'd0, 7'd100, '0, '0, 7'd0, '0));
    // exactly 29 days old: last day of the recency window
    offer(make_beat(ACT_WRITE, 6'd1, 7'd0, DIRECTED_NOW - 48'd29 * DAY_MS, '0, 7'd100, '0));
    // exactly 30 days old, importance and score over range, huge recall count
    offer(make_beat(ACT_WRITE, 6'd2, 7'd127, DIRECTED_NOW - 48'd30 * DAY_MS, '1, 7'd127, '0));
    // access in the future: no days elapsed
    offer(make_beat(ACT_WRITE, 6'd3, 7'd50, DIRECTED_NOW + 48'd5, 16'd1, 7'd5, '0));
    // one ms short of 30 days, importance just under the threshold
    offer(make_beat(ACT_WRITE, 6'd4, 7'd89, DIRECTED_NOW - 48'd30 * DAY_MS + 48'd1, '0, 7'd0, '0));
    offer(make_beat(ACT_WRITE, 6'd5, 7'd0, '1, '0, 7'd0, '0));
    // importance at the threshold
    offer(make_beat(ACT_WRITE, 6'd6, 7'd90, DIRECTED_NOW, '0, 7'd3, '0));
    // same score as slot 4: tie goes to the lower slot
    offer(make_beat(ACT_WRITE, 6'd7, 7'd10, '0, 16'd3, 7'd0, '0));
    offer(make_beat(ACT_VICTIM, '0, '0, '0, '0, '0, '0));
    offer(make_beat(ACT_RESCORE, '0, '0, '0, '0, '0, DIRECTED_NOW));
    // same time again: nothing changes
    offer(make_beat(ACT_RESCORE, '0, '0, '0, '0, '0, DIRECTED_NOW));
    offer(make_beat(ACT_VICTIM, '0, '0, '0, '0, '0, '0));
    // time zero: nothing is later than that
    offer(make_beat(ACT_RESCORE, '0, '0, '0, '0, '0, '0));
    offer(make_beat(ACT_VICTIM, '0, '0, '0, '0, '0, '0));
    // far future: every entry clamps to zero but slot 5, whose access time is the same
    offer(make_beat(ACT_RESCORE, '0, '0, '0, '0, '0, '1));
    offer(make_beat(ACT_VICTIM, '0, '0, '0, '0, '0, '0));
    offer(make_beat(ACT_NONE, 6'd7, '1, '1, '1, '1, '1));

    // threshold zero protects everything: no victim
    load_settings(8'd8, RST_W_IMPORTANCE, RST_W_RECENCY, RST_W_FREQUENCY,
                  RST_W_DECAY, 8'd0);
    offer(make_beat(ACT_VICTIM, '0, '0, '0, '0, '0, '0));
    // threshold at its field maximum: every importance below 127 becomes eligible, slot 2 at 127 is not
    load_settings(8'd8, RST_W_IMPORTANCE, RST_W_RECENCY, RST_W_FREQUENCY,
                  RST_W_DECAY, 8'd127);
    offer(make_beat(ACT_VICTIM, '0, '0, '0, '0, '0, '0));

    // Random phases, each under fresh settings, the idling pattern shifting
    // from sink-heavy to source-heavy to none.
    for (p = 0; p < PHASES; p++) begin
      prefix = written_prefix();
      if (prefix < TABLE_SLOTS) begin
        span_val = (p % 2 == 0) ? 8'(prefix) : 8'($urandom_range(prefix, 1));
      end else begin
        case (p % 4)
          0: span_val = 8'd64;
          1: span_val = 8'hFF;                       // masks to 127, capped at depth
          2: span_val = 8'($urandom_range(127, 65));
          default: span_val = 8'($urandom_range(64, 1));
        endcase
      end
      case (p)
        0: begin
          wi = 8'd0; wr = 8'd0; wf = 8'd0; wd = 8'd0; guard = 8'd101;
        end
        1: begin
          wi = 8'd255; wr = 8'd255; wf = 8'd255; wd = 8'd255; guard = 8'd127;
        end
        2: begin
          wi = RST_W_IMPORTANCE; wr = RST_W_RECENCY; wf = RST_W_FREQUENCY;
          wd = RST_W_DECAY; guard = {1'b0, RST_PROTECT};
        end
        default: begin
          wi = 8'($urandom_range(255, 0));
          wr = 8'($urandom_range(255, 0));
          wf = ($urandom_range(1, 0) != 0) ? 8'($urandom_range(3, 0)) : 8'($urandom_range(255, 0));
          wd = ($urandom_range(1, 0) != 0) ? 8'($urandom_range(10, 0)) : 8'($urandom_range(255, 0));
          guard = (p == 5) ? 8'd0 : 8'($urandom_range(101, 0));
        end
      endcase
      load_settings(span_val, wi, wr, wf, wd, guard);

      if (p < 4) begin
        tx_gap_pct = 26; rx_stall_pct = 57;
      end else if (p < 7) begin
        tx_gap_pct = 57; rx_stall_pct = 26;
      end else begin
        tx_gap_pct = 0; rx_stall_pct = 0;
      end
      // long sink hold-off while the source keeps pushing
      if (p == 7)
        sink_hold_pending = 1'b1;

      for (k = 0; k < BEATS_PER_PHASE; k++)
        offer(random_beat());
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d writes, %0d rescores (%0d scores changed), %0d victim searches",
             tracker.writes_seen, tracker.rescores_seen, tracker.changes_seen,
             tracker.searches_seen);
    $display("  %0d victims found, %0d no-op actions, %0d results checked, %0d mismatches",
             tracker.victims_seen, tracker.idle_seen, tracker.result_count,
             tracker.fault_count);
    if (tracker.fault_count == 0 && tracker.pending() == 0)
      $display("strength_score_eviction_table regression: pass");
    else
      $display("strength_score_eviction_table regression: fail");
    $finish;
  end

endmodule
